// ===== hw/rtl/wyle_code_run_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Wyle-code run decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef WYLE_CODE_RUN_DECODER_MACROS_SVH
`define WYLE_CODE_RUN_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WCRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcrd same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcrd next-cycle check failed");

`endif

// ===== hw/rtl/wcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Wyle-code run decoder package
// Beat types and fixed constants shared by the decoder RTL.
// ----------------------------------------------------------------------------
package wcrd_pkg;

    localparam int BYTE_W          = 8;
    localparam int RUN_LENGTH_W    = 17;
    localparam int COUNT_W         = 32;
    localparam int EMIT_W          = 33;
    localparam int HEADER_BYTES    = 4;
    localparam int LENGTH_MIN_BITS = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              start_of_stream;
    } code_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0]       run_byte;
        logic [RUN_LENGTH_W-1:0] run_length;
        logic                    stream_done;
        logic                    prefix_error;
    } run_beat_t;

endpackage

// ===== hw/rtl/wyle_code_run_decoder.sv =====
// ----------------------------------------------------------------------------
// Wyle-code run decoder
// Parses a byte stream of unary-prefixed run lengths and byte values into
// (value, length) run beats for a downstream repeater.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock while code_stall is low:
// all eight bits of a byte are parsed by one unrolled pass against the
// parse state registers, and a run beat is registered into the output
// register, or into the skid register if the output one holds an untaken
// run. The first four bytes after reset, or the four bytes that begin with
// a byte marked start_of_stream, carry the big-endian output count; the
// byte that finishes a run drops any bits left in it.
// A two-entry output buffer (output register plus skid register) lets the
// input keep flowing while a finished run waits; code_stall rises only when
// both entries hold runs that the downstream side has not taken.
`include "wyle_code_run_decoder_macros.svh"

module wyle_code_run_decoder #(
    parameter int MAX_PREFIX_ONES = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                code_valid,
    output logic                code_stall,
    input  wcrd_pkg::code_beat_t code,
    output logic                run_valid,
    input  logic                run_stall,
    output wcrd_pkg::run_beat_t  run
);

    import wcrd_pkg::*;

    localparam int LEN_W    = MAX_PREFIX_ONES + LENGTH_MIN_BITS;
    localparam int ONES_W   = $clog2(MAX_PREFIX_ONES + 2);
    localparam int BITS_MAX = (LEN_W > BYTE_W) ? LEN_W : BYTE_W;
    localparam int BITS_W   = $clog2(BITS_MAX + 1);
    localparam int HDR_W    = $clog2(HEADER_BYTES);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PREFIX,
        PH_LENGTH,
        PH_VALUE,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t              phase_reg,    phase_next;
    logic [HDR_W-1:0]    hdr_cnt_reg,  hdr_cnt_next;
    logic [COUNT_W-1:0]  expected_reg, expected_next;
    logic [EMIT_W-1:0]   emitted_reg,  emitted_next;
    logic [ONES_W-1:0]   ones_reg,     ones_next;
    logic [LEN_W-1:0]    acc_reg,      acc_next;
    logic [BITS_W-1:0]   bits_reg,     bits_next;
    logic [BYTE_W-1:0]   bacc_reg,     bacc_next;

    logic                out_valid_reg;
    run_beat_t           out_reg;
    logic                skid_valid_reg;
    run_beat_t           skid_reg;

    logic                code_fire;
    logic                pop;
    logic                push;
    logic                emit;
    logic                err;
    run_beat_t           result;

    logic [LEN_W:0]      len;
    logic [EMIT_W:0]     sum;
    logic [EMIT_W-1:0]   sum_sat;
    logic                done;

    assign code_stall = skid_valid_reg;
    assign code_fire  = code_valid && !code_stall;
    assign pop        = out_valid_reg && !run_stall;
    assign push       = code_fire && (emit || err);
    assign run_valid  = out_valid_reg;
    assign run        = out_reg;

    // One pass over the eight bits of the incoming byte. Parsing stops at
    // the first run or error, so later bits of that byte are dropped.
    always_comb
    begin
        logic stop;
        logic bit_v;

        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        expected_next = expected_reg;
        emitted_next  = emitted_reg;
        ones_next     = ones_reg;
        acc_next      = acc_reg;
        bits_next     = bits_reg;
        bacc_next     = bacc_reg;
        emit          = 1'b0;
        err           = 1'b0;
        stop          = 1'b0;
        bit_v         = 1'b0;
        len           = '0;
        sum           = '0;
        sum_sat       = '0;
        done          = 1'b0;

        if (code.start_of_stream)
        begin
            phase_next    = PH_HEADER;
            hdr_cnt_next  = '0;
            expected_next = '0;
            emitted_next  = '0;
            ones_next     = '0;
            acc_next      = '0;
            bits_next     = '0;
            bacc_next     = '0;
        end

        case (phase_next)
            PH_HEADER:
            begin
                expected_next = {expected_next[COUNT_W-BYTE_W-1:0], code.stream_byte};
                if (hdr_cnt_next == HDR_W'(HEADER_BYTES - 1))
                begin
                    hdr_cnt_next = '0;
                    phase_next   = (expected_next == '0) ? PH_DONE : PH_PREFIX;
                    ones_next    = '0;
                    acc_next     = '0;
                    bits_next    = '0;
                    bacc_next    = '0;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_next + HDR_W'(1);
                end
            end
            PH_PREFIX, PH_LENGTH, PH_VALUE:
            begin
                for (int i = BYTE_W - 1; i >= 0; i--)
                begin
                    bit_v = code.stream_byte[i];
                    if (!stop)
                    begin
                        case (phase_next)
                            PH_PREFIX:
                            begin
                                if (bit_v)
                                begin
                                    ones_next = ones_next + ONES_W'(1);
                                    if (ones_next > ONES_W'(MAX_PREFIX_ONES))
                                    begin
                                        err        = 1'b1;
                                        stop       = 1'b1;
                                        phase_next = PH_ERROR;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_LENGTH;
                                    acc_next   = '0;
                                    bits_next  = '0;
                                end
                            end
                            PH_LENGTH:
                            begin
                                acc_next  = acc_next | (LEN_W'(bit_v) << bits_next);
                                bits_next = bits_next + BITS_W'(1);
                                if ((BITS_W+1)'(bits_next) >=
                                    (BITS_W+1)'(ones_next) + (BITS_W+1)'(LENGTH_MIN_BITS))
                                begin
                                    phase_next = PH_VALUE;
                                    bits_next  = '0;
                                    bacc_next  = '0;
                                end
                            end
                            PH_VALUE:
                            begin
                                bacc_next = {bacc_next[BYTE_W-2:0], bit_v};
                                bits_next = bits_next + BITS_W'(1);
                                if (bits_next >= BITS_W'(BYTE_W))
                                begin
                                    emit = 1'b1;
                                    stop = 1'b1;
                                end
                            end
                            default:
                            begin
                                stop = 1'b1;
                            end
                        endcase
                    end
                end

                if (emit)
                begin
                    len          = {1'b0, acc_next} + (LEN_W+1)'(1);
                    sum          = (EMIT_W+1)'(emitted_next) + (EMIT_W+1)'(len);
                    sum_sat      = sum[EMIT_W] ? '1 : sum[EMIT_W-1:0];
                    done         = sum_sat >= EMIT_W'(expected_next);
                    emitted_next = sum_sat;
                    ones_next    = '0;
                    bits_next    = '0;
                    acc_next     = '0;
                    phase_next   = done ? PH_DONE : PH_PREFIX;
                end
            end
            default:
            begin
                // Finished or halted: the byte is consumed with no effect.
            end
        endcase

        result.run_byte     = emit ? bacc_next : '0;
        result.run_length   = emit ? RUN_LENGTH_W'(len) : '0;
        result.stream_done  = emit && done;
        result.prefix_error = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            expected_reg   <= '0;
            emitted_reg    <= '0;
            ones_reg       <= '0;
            acc_reg        <= '0;
            bits_reg       <= '0;
            bacc_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (code_fire)
            begin
                phase_reg    <= phase_next;
                hdr_cnt_reg  <= hdr_cnt_next;
                expected_reg <= expected_next;
                emitted_reg  <= emitted_next;
                ones_reg     <= ones_next;
                acc_reg      <= acc_next;
                bits_reg     <= bits_next;
                bacc_reg     <= bacc_next;
            end

            // The skid entry is always older than a new result, and no new
            // beat arrives while it is occupied.
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                    out_reg       <= result;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= result;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                    skid_reg       <= result;
                end
            end
        end
    end

    `WCRD_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `WCRD_ASSERT_NEXT(a_push_to_skid, clk, rst_n, push && out_valid_reg && run_stall, skid_valid_reg)
    `WCRD_ASSERT_NEXT(a_drain_empty, clk, rst_n, pop && !skid_valid_reg && !push, !run_valid)
    `WCRD_ASSERT_NEXT(a_error_halts, clk, rst_n, push && result.prefix_error, phase_reg == PH_ERROR)
    `WCRD_ASSERT_NEXT(a_done_stops, clk, rst_n, push && result.stream_done, phase_reg == PH_DONE)

endmodule
